/* rtl/ohlc_pkg.sv */
// Shared types and constants of the OHLC bar aggregator.
package ohlc_pkg;

    localparam int CFG_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int EXT_START = 100000;
    localparam int EXT_MIN_WIDTH = 18;

    typedef enum logic [1:0] {
        MODE_GROUP  = 2'd0,
        MODE_WALK   = 2'd1,
        MODE_DELTA  = 2'd2,
        MODE_DIRECT = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MODE        = 2'd0,
        REG_BAR_WINDOW  = 2'd1,
        REG_SKIP_COUNT  = 2'd2,
        REG_DELTA_RANGE = 2'd3
    } reg_index_t;

endpackage

/* rtl/ohlc_if.sv */
// Valid/ready stream interfaces for the sample input and the bar output.
interface ohlc_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         series_end;

    modport source (output valid, output sample, output series_end, input ready);
    modport sink (input valid, input sample, input series_end, output ready);
endinterface

interface ohlc_out_if #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] bar_open;
    logic signed [DATA_WIDTH-1:0] bar_high;
    logic signed [DATA_WIDTH-1:0] bar_low;
    logic signed [DATA_WIDTH-1:0] bar_close;
    logic [COUNT_WIDTH-1:0]       bar_number;
    logic signed [DATA_WIDTH-1:0] series_max;
    logic signed [DATA_WIDTH-1:0] series_min;
    logic                         final_bar;

    modport source (
        output valid, output bar_open, output bar_high, output bar_low, output bar_close,
        output bar_number, output series_max, output series_min, output final_bar,
        input ready
    );
    modport sink (
        input valid, input bar_open, input bar_high, input bar_low, input bar_close,
        input bar_number, input series_max, input series_min, input final_bar,
        output ready
    );
endinterface

/* rtl/ohlc_bar_aggregator.sv */
// Top level of the OHLC bar aggregator: ports, configuration and output buffering.
//
// Samples enter on in_ch (valid/ready) with a series_end flag on the last item
// of a series. Each transfer yields zero or one bar on out_ch. The plain write
// port (cfg_write, cfg_index, cfg_data) sets mode, bar_window, skip_count and
// delta_range; write it only while no item is in flight.
// An accepted item updates the series state and writes its bar, if any, into
// the output buffer at the same clock edge. The block takes one sample per
// cycle while the buffer has room; the rate is set by the series logic, which
// computes each bar combinationally from its registered state. A two-entry
// output buffer lets input transfers continue while one finished bar waits;
// when both entries are full, in_ch.ready drops until a bar is transferred.
// Reset clears the configuration to mode 0, window 1, no skip, zero range,
// empties the buffer and starts a fresh series with extremes at -100000 and
// 100000.
module ohlc_bar_aggregator #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  ohlc_pkg::reg_index_t           cfg_index,
    input  logic [ohlc_pkg::CFG_WIDTH-1:0] cfg_data,
    ohlc_in_if.sink                        in_ch,
    ohlc_out_if.source                     out_ch
);
    import ohlc_pkg::*;

    localparam int RES_WIDTH = 6 * DATA_WIDTH + COUNT_WIDTH + 1;

    logic                 accept;
    logic                 emit;
    logic                 has_room;
    logic [RES_WIDTH-1:0] core_result;
    logic [RES_WIDTH-1:0] out_data;

    assign in_ch.ready = has_room;
    assign accept      = in_ch.valid && has_room;

    ohlc_core #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .sample     (in_ch.sample),
        .series_end (in_ch.series_end),
        .emit       (emit),
        .result     (core_result)
    );

    ohlc_obuf #(
        .WIDTH (RES_WIDTH)
    ) u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_data (core_result),
        .has_room  (has_room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign {out_ch.bar_open, out_ch.bar_high, out_ch.bar_low, out_ch.bar_close,
            out_ch.bar_number, out_ch.series_max, out_ch.series_min,
            out_ch.final_bar} = out_data;

endmodule

/* rtl/ohlc_core.sv */
// Configuration registers, series state and combinational bar computation.
module ohlc_core #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16,
    localparam int RES_WIDTH  = 6 * DATA_WIDTH + COUNT_WIDTH + 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  ohlc_pkg::reg_index_t                cfg_index,
    input  logic [ohlc_pkg::CFG_WIDTH-1:0]      cfg_data,
    input  logic                                accept,
    input  logic signed [DATA_WIDTH-1:0]        sample,
    input  logic                                series_end,
    output logic                                emit,
    output logic [RES_WIDTH-1:0]                result
);
    import ohlc_pkg::*;

    localparam int SUM_WIDTH = (DATA_WIDTH > CFG_WIDTH ? DATA_WIDTH : CFG_WIDTH) + 2;
    localparam int EXT_WIDTH = (DATA_WIDTH > EXT_MIN_WIDTH ? DATA_WIDTH : EXT_MIN_WIDTH);
    localparam logic signed [SUM_WIDTH-1:0] SAT_MAX =
        SUM_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_WIDTH-1:0] SAT_MIN = -SAT_MAX - SUM_WIDTH'(1);
    localparam logic signed [SUM_WIDTH-1:0] STEP_ONE = SUM_WIDTH'(1);
    localparam logic signed [EXT_WIDTH-1:0] EXT_HIGH_START = -EXT_WIDTH'(EXT_START);
    localparam logic signed [EXT_WIDTH-1:0] EXT_LOW_START = EXT_WIDTH'(EXT_START);

    function automatic logic signed [DATA_WIDTH-1:0] sat_add(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [SUM_WIDTH-1:0]  b
    );
        logic signed [SUM_WIDTH-1:0] sum;
        sum = SUM_WIDTH'(a) + b;
        if (sum > SAT_MAX)
        begin
            sum = SAT_MAX;
        end
        else if (sum < SAT_MIN)
        begin
            sum = SAT_MIN;
        end
        return sum[DATA_WIDTH-1:0];
    endfunction

    mode_t                  mode_reg;
    logic [CFG_WIDTH-1:0]   bar_window_reg;
    logic [CFG_WIDTH-1:0]   skip_count_reg;
    logic [CFG_WIDTH-1:0]   delta_range_reg;

    logic signed [DATA_WIDTH-1:0] level_reg, level_next;
    logic signed [DATA_WIDTH-1:0] prev_reg, prev_next;
    logic signed [DATA_WIDTH-1:0] open_reg, open_next;
    logic signed [DATA_WIDTH-1:0] high_reg, high_next;
    logic signed [DATA_WIDTH-1:0] low_reg, low_next;
    logic [CFG_WIDTH-1:0]         window_pos_reg, window_pos_next;
    logic [COUNT_WIDTH-1:0]       bar_count_reg, bar_count_next;
    logic [CFG_WIDTH-1:0]         skip_cnt_reg, skip_cnt_next;
    logic signed [EXT_WIDTH-1:0]  ext_high_reg, ext_high_next;
    logic signed [EXT_WIDTH-1:0]  ext_low_reg, ext_low_next;
    logic                         first_reg, first_next;

    logic signed [DATA_WIDTH-1:0] bar_o, bar_h, bar_l, bar_c, value, delta;
    logic signed [EXT_WIDTH-1:0]  ext_high_upd, ext_low_upd;
    logic [CFG_WIDTH-1:0]         window;
    logic                         closes;
    logic                         skipping;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_GROUP;
            bar_window_reg  <= CFG_WIDTH'(1);
            skip_count_reg  <= '0;
            delta_range_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:        mode_reg        <= mode_t'(cfg_data[1:0]);
                REG_BAR_WINDOW:  bar_window_reg  <= cfg_data;
                REG_SKIP_COUNT:  skip_count_reg  <= cfg_data;
                REG_DELTA_RANGE: delta_range_reg <= cfg_data;
                default:         mode_reg        <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        level_next      = level_reg;
        prev_next       = prev_reg;
        open_next       = open_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        window_pos_next = window_pos_reg;
        bar_count_next  = bar_count_reg;
        skip_cnt_next   = skip_cnt_reg;
        ext_high_next   = ext_high_reg;
        ext_low_next    = ext_low_reg;
        first_next      = first_reg;
        emit            = 1'b0;
        bar_o           = open_reg;
        bar_h           = high_reg;
        bar_l           = low_reg;
        bar_c           = sample;
        value           = sample;
        delta           = sample;
        ext_high_upd    = ext_high_reg;
        ext_low_upd     = ext_low_reg;
        window          = (bar_window_reg == '0) ? CFG_WIDTH'(1) : bar_window_reg;
        closes          = ({1'b0, window_pos_reg} + (CFG_WIDTH + 1)'(1) >= {1'b0, window})
                          || series_end;
        skipping        = skip_cnt_reg < skip_count_reg;

        if (skipping)
        begin
            skip_cnt_next = skip_cnt_reg + CFG_WIDTH'(1);
        end
        else
        begin
            case (mode_reg)
                MODE_GROUP, MODE_WALK:
                begin
                    if (mode_reg == MODE_WALK)
                    begin
                        level_next = sat_add(level_reg, (sample != '0) ? STEP_ONE : -STEP_ONE);
                        value = level_next;
                    end
                    if (window_pos_reg == '0)
                    begin
                        open_next = value;
                        high_next = value;
                        low_next  = value;
                    end
                    else
                    begin
                        high_next = (value > high_reg) ? value : high_reg;
                        low_next  = (value < low_reg) ? value : low_reg;
                    end
                    bar_o = open_next;
                    bar_h = high_next;
                    bar_l = low_next;
                    bar_c = value;
                    emit  = closes;
                    window_pos_next = closes ? '0 : window_pos_reg + CFG_WIDTH'(1);
                end
                default:
                begin
                    if (mode_reg == MODE_DELTA)
                    begin
                        delta = sat_add(sample,
                                        -$signed(SUM_WIDTH'(delta_range_reg >> 1)));
                        level_next = sat_add(level_reg, SUM_WIDTH'(delta));
                        bar_o = level_reg;
                        bar_c = level_next;
                    end
                    else
                    begin
                        bar_o = first_reg ? sample : prev_reg;
                        bar_c = sample;
                    end
                    bar_h = (bar_o > bar_c) ? bar_o : bar_c;
                    bar_l = (bar_o < bar_c) ? bar_o : bar_c;
                    open_next = bar_o;
                    high_next = bar_h;
                    low_next  = bar_l;
                    window_pos_next = '0;
                    emit = 1'b1;
                end
            endcase
            prev_next  = sample;
            first_next = 1'b0;
        end

        if (emit)
        begin
            if (EXT_WIDTH'(bar_h) > ext_high_reg)
            begin
                ext_high_upd = EXT_WIDTH'(bar_h);
            end
            if (EXT_WIDTH'(bar_l) < ext_low_reg)
            begin
                ext_low_upd = EXT_WIDTH'(bar_l);
            end
            ext_high_next  = ext_high_upd;
            ext_low_next   = ext_low_upd;
            bar_count_next = bar_count_reg + COUNT_WIDTH'(1);
        end

        if (series_end)
        begin
            level_next      = '0;
            window_pos_next = '0;
            bar_count_next  = '0;
            skip_cnt_next   = '0;
            ext_high_next   = EXT_HIGH_START;
            ext_low_next    = EXT_LOW_START;
            first_next      = 1'b1;
        end

        result = {bar_o, bar_h, bar_l, bar_c, bar_count_reg,
                  ext_high_upd[DATA_WIDTH-1:0], ext_low_upd[DATA_WIDTH-1:0], series_end};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            prev_reg       <= '0;
            open_reg       <= '0;
            high_reg       <= '0;
            low_reg        <= '0;
            window_pos_reg <= '0;
            bar_count_reg  <= '0;
            skip_cnt_reg   <= '0;
            ext_high_reg   <= EXT_HIGH_START;
            ext_low_reg    <= EXT_LOW_START;
            first_reg      <= 1'b1;
        end
        else if (accept)
        begin
            level_reg      <= level_next;
            prev_reg       <= prev_next;
            open_reg       <= open_next;
            high_reg       <= high_next;
            low_reg        <= low_next;
            window_pos_reg <= window_pos_next;
            bar_count_reg  <= bar_count_next;
            skip_cnt_reg   <= skip_cnt_next;
            ext_high_reg   <= ext_high_next;
            ext_low_reg    <= ext_low_next;
            first_reg      <= first_next;
        end
    end

    a_restart_after_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && series_end) |=> (first_reg && bar_count_reg == '0 && skip_cnt_reg == '0)
    ) else $error("series state not restarted after the last item");

    a_window_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && !skipping && (mode_reg == MODE_DELTA || mode_reg == MODE_DIRECT))
            |=> window_pos_reg == '0
    ) else $error("window position kept in a per-item mode");

endmodule

/* rtl/ohlc_obuf.sv */
// Two-entry output buffer that decouples bar results from the output handshake.
module ohlc_obuf #(
    parameter int WIDTH = 225
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic [1:0]       count_reg, count_next;
    logic [WIDTH-1:0] slot0_reg, slot0_next;
    logic [WIDTH-1:0] slot1_reg, slot1_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign has_room  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (push)
        begin
            if (count_next == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2
    ) else $error("result written into a full buffer");

    a_shift_on_pop: assert property (
        @(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg == 2'd2) |=> slot0_reg == $past(slot1_reg)
    ) else $error("second entry lost on transfer");

endmodule

/* bench/tb_ohlc_bar_aggregator.sv */
// Self-checking testbench for the OHLC bar aggregator with a directed table and random series.
module tb_ohlc_bar_aggregator;
    timeunit 1ns;
    timeprecision 1ps;

    import ohlc_pkg::*;

    localparam int DW = 32;
    localparam int CW = 16;
    localparam logic signed [DW-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] S_MIN = 32'sh8000_0000;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 960;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic signed [DW-1:0] bar_open;
        logic signed [DW-1:0] bar_high;
        logic signed [DW-1:0] bar_low;
        logic signed [DW-1:0] bar_close;
        logic [CW-1:0]        bar_number;
        logic signed [DW-1:0] series_max;
        logic signed [DW-1:0] series_min;
        logic                 final_bar;
    } bar_t;

    typedef struct packed {
        logic                 do_cfg;
        mode_t                mode;
        logic [15:0]          window;
        logic [15:0]          skip;
        logic [15:0]          delta;
        logic signed [DW-1:0] sample;
        logic                 last;
        logic                 typed;
        bar_t                 bar;
    } step_row_t;

    typedef struct packed {
        logic typed;
        bar_t bar;
    } offer_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    reg_index_t           cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    ohlc_in_if #(.DATA_WIDTH(DW)) in_ch ();
    ohlc_out_if #(.DATA_WIDTH(DW), .COUNT_WIDTH(CW)) out_ch ();

    ohlc_bar_aggregator #(
        .DATA_WIDTH(DW),
        .COUNT_WIDTH(CW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // Mirror of the configuration and the series state.
    mode_t                pm_mode;
    logic [15:0]          pm_window;
    logic [15:0]          pm_skip;
    logic [15:0]          pm_delta;
    logic signed [DW-1:0] sr_level;
    logic signed [DW-1:0] sr_prev;
    logic signed [DW-1:0] sr_open;
    logic signed [DW-1:0] sr_high;
    logic signed [DW-1:0] sr_low;
    logic signed [DW-1:0] sr_ext_high;
    logic signed [DW-1:0] sr_ext_low;
    logic [15:0]          sr_pos;
    logic [15:0]          sr_skipped;
    logic [CW-1:0]        sr_bar_count;
    logic                 sr_first;

    offer_t offered[$];
    bar_t   pending_bars[$];

    int  errors = 0;
    int  idle_cycles = 0;
    int  items_taken = 0;
    int  items_used = 0;
    int  bars_checked = 0;
    int  settings_done = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  long_hold = 1'b0;

    initial clk = 1'b0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    function automatic logic signed [DW-1:0] clamp_add(input logic signed [DW-1:0] a,
                                                       input longint b);
        longint sum;
        sum = longint'(a) + b;
        if (sum > longint'(S_MAX))
            return S_MAX;
        if (sum < longint'(S_MIN))
            return S_MIN;
        return sum[DW-1:0];
    endfunction

    task automatic restart_series();
        sr_level = '0;
        sr_pos = '0;
        sr_bar_count = '0;
        sr_skipped = '0;
        sr_ext_high = -EXT_START;
        sr_ext_low = EXT_START;
        sr_first = 1'b1;
    endtask

    task automatic reset_predictor();
        pm_mode = MODE_GROUP;
        pm_window = 16'd1;
        pm_skip = '0;
        pm_delta = '0;
        sr_prev = '0;
        sr_open = '0;
        sr_high = '0;
        sr_low = '0;
        restart_series();
    endtask

    task automatic build_bar(input logic signed [DW-1:0] s, input logic last,
                             output logic emitted, output bar_t b);
        logic signed [DW-1:0] v;
        logic signed [DW-1:0] o;
        logic signed [DW-1:0] h;
        logic signed [DW-1:0] l;
        logic signed [DW-1:0] c;
        logic signed [DW-1:0] d;
        int win;
        emitted = 1'b0;
        b = '0;
        win = (pm_window == 0) ? 1 : int'(pm_window);
        if (sr_skipped < pm_skip)
        begin
            sr_skipped++;
            if (last)
                restart_series();
            return;
        end
        items_used++;
        if (pm_mode == MODE_GROUP || pm_mode == MODE_WALK)
        begin
            if (pm_mode == MODE_WALK)
            begin
                sr_level = clamp_add(sr_level, (s != 0) ? 1 : -1);
                v = sr_level;
            end
            else
                v = s;
            if (sr_pos == 0)
            begin
                sr_open = v;
                sr_high = v;
                sr_low = v;
            end
            else
            begin
                if (v > sr_high)
                    sr_high = v;
                if (v < sr_low)
                    sr_low = v;
            end
            o = sr_open;
            h = sr_high;
            l = sr_low;
            c = v;
            if (int'(sr_pos) + 1 >= win || last)
            begin
                emitted = 1'b1;
                sr_pos = '0;
            end
            else
                sr_pos++;
        end
        else
        begin
            if (pm_mode == MODE_DELTA)
            begin
                d = clamp_add(s, -longint'(pm_delta >> 1));
                o = sr_level;
                sr_level = clamp_add(sr_level, longint'(d));
                c = sr_level;
            end
            else
            begin
                o = sr_first ? s : sr_prev;
                c = s;
            end
            h = (o > c) ? o : c;
            l = (o < c) ? o : c;
            sr_open = o;
            sr_high = h;
            sr_low = l;
            sr_pos = '0;
            emitted = 1'b1;
        end
        sr_prev = s;
        sr_first = 1'b0;
        if (!emitted)
            return;
        if (h > sr_ext_high)
            sr_ext_high = h;
        if (l < sr_ext_low)
            sr_ext_low = l;
        b.bar_open = o;
        b.bar_high = h;
        b.bar_low = l;
        b.bar_close = c;
        b.bar_number = sr_bar_count;
        b.series_max = sr_ext_high;
        b.series_min = sr_ext_low;
        b.final_bar = last;
        sr_bar_count++;
        if (last)
            restart_series();
    endtask

    task automatic report_mismatch(input string what, input logic signed [DW-1:0] got,
                                   input logic signed [DW-1:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at bar %0d: %s got %0d expected %0d", bars_checked, what, got,
                     want);
    endtask

    task automatic compare_field(input string what, input logic signed [DW-1:0] got,
                                 input logic signed [DW-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Output checks come before input prediction so a bar is never matched
    // against an expectation pushed at the same edge.
    always @(posedge clk)
    begin
        offer_t offer;
        bar_t   want;
        bar_t   predicted;
        logic   emitted;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MODE:        pm_mode = mode_t'(cfg_data[1:0]);
                    REG_BAR_WINDOW:  pm_window = cfg_data;
                    REG_SKIP_COUNT:  pm_skip = cfg_data;
                    REG_DELTA_RANGE: pm_delta = cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_bars.size() == 0)
                    report_mismatch("bar with no expectation, open", out_ch.bar_open, 0);
                else
                begin
                    want = pending_bars.pop_front();
                    compare_field("bar_open", out_ch.bar_open, want.bar_open);
                    compare_field("bar_high", out_ch.bar_high, want.bar_high);
                    compare_field("bar_low", out_ch.bar_low, want.bar_low);
                    compare_field("bar_close", out_ch.bar_close, want.bar_close);
                    compare_field("bar_number", DW'(out_ch.bar_number), DW'(want.bar_number));
                    compare_field("series_max", out_ch.series_max, want.series_max);
                    compare_field("series_min", out_ch.series_min, want.series_min);
                    compare_field("final_bar", DW'(out_ch.final_bar), DW'(want.final_bar));
                end
                bars_checked++;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                offer = offered.pop_front();
                build_bar(in_ch.sample, in_ch.series_end, emitted, predicted);
                if (offer.typed)
                    pending_bars.push_back(offer.bar);
                else if (emitted)
                    pending_bars.push_back(predicted);
                items_taken++;
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** ohlc_bar_aggregator: FAILED **");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic step_row_t setting(input mode_t m, input logic [15:0] w,
                                          input logic [15:0] sk, input logic [15:0] d);
        step_row_t r = '0;
        r.do_cfg = 1'b1;
        r.mode = m;
        r.window = w;
        r.skip = sk;
        r.delta = d;
        return r;
    endfunction

    function automatic step_row_t sample_row(input logic signed [DW-1:0] s, input logic last);
        step_row_t r = '0;
        r.sample = s;
        r.last = last;
        return r;
    endfunction

    // A bar whose open, high, low and close all equal the sample.
    function automatic step_row_t flat_bar(input logic signed [DW-1:0] s, input logic last,
                                           input logic [CW-1:0] n,
                                           input logic signed [DW-1:0] mx,
                                           input logic signed [DW-1:0] mn);
        step_row_t r = '0;
        r.sample = s;
        r.last = last;
        r.typed = 1'b1;
        r.bar = '{s, s, s, s, n, mx, mn, last};
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_sample();
        case ($urandom_range(6))
            0, 1: return $urandom;
            2: return int'($urandom_range(40)) - 20;
            3: return ($urandom_range(1) ? 1 : -1) * (99990 + int'($urandom_range(20)));
            4:
            begin
                case ($urandom_range(3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return S_MIN + 1;
                    default: return S_MAX - 1;
                endcase
            end
            5: return $urandom_range(1);
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_sample(input logic signed [DW-1:0] s, input logic last,
                                input logic typed, input bar_t bar);
        offer_t o;
        o.typed = typed;
        o.bar = bar;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        offered.push_back(o);
        in_ch.valid <= 1'b1;
        in_ch.sample <= s;
        in_ch.series_end <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic drain_bars();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic apply_setting(input mode_t m, input logic [15:0] w, input logic [15:0] sk,
                                 input logic [15:0] d);
        drain_bars();
        write_reg(REG_MODE, {14'd0, m});
        write_reg(REG_BAR_WINDOW, w);
        write_reg(REG_SKIP_COUNT, sk);
        write_reg(REG_DELTA_RANGE, d);
        cfg_write <= 1'b0;
        settings_done++;
    endtask

    // One random setting followed by a few series; the last may stay open.
    task automatic random_segment(input bit hold);
        mode_t       m;
        logic [15:0] w;
        logic [15:0] sk;
        logic [15:0] d;
        int          n_series;
        int          len;
        bit          open_end;
        logic        last;
        m = mode_t'($urandom_range(3));
        case ($urandom_range(9))
            0: w = 16'd0;
            1: w = 16'hFFFF;
            2: w = 16'd1;
            default: w = 16'($urandom_range(8, 2));
        endcase
        case ($urandom_range(9))
            0: sk = 16'($urandom_range(20));
            1, 2, 3, 4: sk = 16'd0;
            default: sk = 16'($urandom_range(3));
        endcase
        case ($urandom_range(4))
            0: d = 16'd0;
            1: d = 16'hFFFF;
            2: d = 16'($urandom_range(40));
            default: d = 16'($urandom);
        endcase
        if (hold)
        begin
            m = MODE_DIRECT;
            sk = 16'd0;
        end
        apply_setting(m, w, sk, d);
        if (hold)
            long_hold = 1'b1;
        n_series = hold ? 8 : $urandom_range(6, 2);
        open_end = ($urandom_range(2) == 0);
        for (int k = 0; k < n_series; k++)
        begin
            len = $urandom_range(14, 1);
            for (int j = 0; j < len; j++)
            begin
                last = (j == len - 1) && !(open_end && k == n_series - 1);
                if ($urandom_range(19) == 0)
                    last = 1'($urandom_range(1));
                offer_sample(rand_sample(), last, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        step_row_t steps[$];
        int        goal;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.series_end = 1'b0;
        reset_predictor();
        steps = '{
            flat_bar(0, 1'b0, 0, 0, 0),
            flat_bar(S_MAX, 1'b0, 1, S_MAX, 0),
            flat_bar(S_MIN, 1'b1, 2, S_MAX, S_MIN),
            flat_bar(-200000, 1'b0, 0, -EXT_START, -200000),
            flat_bar(200000, 1'b1, 1, 200000, -200000),
            setting(MODE_GROUP, 16'd3, 16'd1, 16'd0),
            sample_row(10, 1'b0),
            sample_row(7, 1'b0),
            sample_row(-3, 1'b0),
            sample_row(9, 1'b0),
            sample_row(4, 1'b1),
            sample_row(1, 1'b0),
            sample_row(2, 1'b1),
            setting(MODE_WALK, 16'd0, 16'd0, 16'd0),
            sample_row(1, 1'b0),
            sample_row(0, 1'b0),
            setting(MODE_DELTA, 16'd1, 16'd0, 16'd0),
            sample_row(S_MAX, 1'b0),
            sample_row(S_MAX, 1'b0),
            sample_row(S_MIN, 1'b0),
            sample_row(S_MIN, 1'b0),
            setting(MODE_WALK, 16'd4, 16'd0, 16'd0),
            sample_row(0, 1'b0),
            sample_row(1, 1'b0),
            setting(MODE_DIRECT, 16'd4, 16'd0, 16'd0),
            sample_row(100, 1'b0),
            sample_row(-100, 1'b1),
            sample_row(55, 1'b0),
            setting(MODE_DELTA, 16'd1, 16'd0, 16'hFFFF),
            sample_row(S_MIN, 1'b0),
            sample_row(0, 1'b1),
            setting(MODE_GROUP, 16'hFFFF, 16'hFFFF, 16'd0),
            sample_row(3, 1'b1)
        };
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 8;
        recv_idle_pct = 45;
        foreach (steps[i])
        begin
            if (steps[i].do_cfg)
                apply_setting(steps[i].mode, steps[i].window, steps[i].skip, steps[i].delta);
            else
                offer_sample(steps[i].sample, steps[i].last, steps[i].typed, steps[i].bar);
        end
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 8 : 0;
            goal = items_taken + RANDOM_ITEMS / 3;
            random_segment(phase == 2);
            while (items_taken < goal)
                random_segment(1'b0);
        end
        drain_bars();
        $display("Run covered %0d transfers in (%0d used for bars) and %0d bars out,",
                 items_taken, items_used, bars_checked);
        $display("over %0d register settings in all four modes, with stalls on both sides.",
                 settings_done);
        if (errors == 0)
            $display("** ohlc_bar_aggregator: PASSED **");
        else
            $display("** ohlc_bar_aggregator: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/ohlc_pkg.sv
rtl/ohlc_if.sv
rtl/ohlc_core.sv
rtl/ohlc_obuf.sv
rtl/ohlc_bar_aggregator.sv
bench/tb_ohlc_bar_aggregator.sv
